// ----- src/ohce_pkg.sv -----
// Shared constants, codes and types of the one-hot cross-entropy unit.
package ohce_pkg;

	localparam int PROB_W = 16;
	localparam int LOSS_W = 24;
	localparam int GRAD_W = 32;

	localparam logic [PROB_W-1:0] ONE_Q15  = 16'h8000;
	localparam logic [31:0]       LN2_Q32  = 32'd2977044472;
	localparam logic [LOSS_W-1:0] LOSS_MAX = 24'hFFFFFF;

	localparam logic signed [GRAD_W-1:0] GRAD_MAX = 32'sh7FFFFFFF;
	localparam logic signed [GRAD_W-1:0] GRAD_MIN = 32'sh80000000;

	localparam logic OP_FWD    = 1'b0;
	localparam logic OP_BWD    = 1'b1;
	localparam logic KIND_LOSS = 1'b0;
	localparam logic KIND_GRAD = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOG,
		ST_DIV,
		ST_EMIT
	} top_state_t;

	typedef enum logic [2:0] {
		LG_IDLE,
		LG_NORM,
		LG_SQR,
		LG_SCALE,
		LG_DONE
	} log_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_DONE
	} div_state_t;

endpackage

// ----- src/ohce_in_if.sv -----
// Input channel: one probability element with its target and gradient operands.
interface ohce_in_if;
	import ohce_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [PROB_W-1:0]        prob;
	logic                     target_hot;
	logic                     row_last;
	logic signed [GRAD_W-1:0] upstream_grad;
	logic signed [GRAD_W-1:0] grad_in;

	modport source (
		output valid, op, prob, target_hot, row_last, upstream_grad, grad_in,
		input  ready
	);
	modport sink (
		input  valid, op, prob, target_hot, row_last, upstream_grad, grad_in,
		output ready
	);
endinterface

// ----- src/ohce_out_if.sv -----
// Output channel: one row loss or one element gradient result.
interface ohce_out_if;
	import ohce_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     result_kind;
	logic [LOSS_W-1:0]        loss;
	logic signed [GRAD_W-1:0] grad_out;
	logic                     saturated;

	modport source (
		output valid, result_kind, loss, grad_out, saturated,
		input  ready
	);
	modport sink (
		input  valid, result_kind, loss, grad_out, saturated,
		output ready
	);
endinterface

// ----- src/ohce_log.sv -----
// Iterative -ln(p): normalize shift, 16 squarings and ln2 scaling on one multiplier.
module ohce_log (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ohce_pkg::PROB_W-1:0] prob,
	output ohce_pkg::unit_stat_t        stat,
	output logic [ohce_pkg::LOSS_W-1:0] loss
);
	import ohce_pkg::*;

	log_state_t        state_q, state_d;
	logic [PROB_W-1:0] p_q;
	logic [3:0]        k_q;
	logic [30:0]       y_q;
	logic [15:0]       frac_q;
	logic [3:0]        cnt_q;
	logic [LOSS_W-1:0] loss_q;

	logic [31:0]       mul_a, mul_b;
	logic [63:0]       prod;
	logic [31:0]       sq;
	logic [19:0]       l2;
	logic [LOSS_W-1:0] rnd;

	// -log2 p = k - frac, Q.16
	assign l2 = {k_q, 16'b0} - {4'b0, frac_q};

	always_comb begin
		if (state_q == LG_SCALE) begin
			mul_a = {12'b0, l2};
			mul_b = LN2_Q32;
		end else begin
			mul_a = {1'b0, y_q};
			mul_b = {1'b0, y_q};
		end
	end

	assign prod = mul_a * mul_b;
	assign sq   = prod[61:30];
	assign rnd  = prod[55:32] + {{(LOSS_W-1){1'b0}}, prod[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			LG_IDLE:  if (start) state_d = LG_NORM;
			LG_NORM:  if (p_q[PROB_W-1]) state_d = LG_SQR;
			LG_SQR:   if (cnt_q == 4'd15) state_d = LG_SCALE;
			LG_SCALE: state_d = LG_DONE;
			LG_DONE:  state_d = LG_IDLE;
			default:  state_d = LG_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			LG_IDLE: begin
				if (start) begin
					p_q <= prob;
					k_q <= '0;
				end
			end
			LG_NORM: begin
				if (!p_q[PROB_W-1]) begin
					p_q <= {p_q[PROB_W-2:0], 1'b0};
					k_q <= k_q + 4'd1;
				end else begin
					y_q    <= {p_q, 15'b0};
					frac_q <= '0;
					cnt_q  <= '0;
				end
			end
			LG_SQR: begin
				// square lands in [1,4); fold back to [1,2) and take the bit
				y_q    <= sq[31] ? sq[31:1] : sq[30:0];
				frac_q <= {frac_q[14:0], sq[31]};
				cnt_q  <= cnt_q + 4'd1;
			end
			LG_SCALE: loss_q <= rnd;
			default: ;
		endcase
	end

	assign stat.busy = (state_q != LG_IDLE);
	assign stat.done = (state_q == LG_DONE);
	assign loss      = loss_q;

endmodule

// ----- src/ohce_div.sv -----
// Restoring shift-subtract divider: (mag << 15) / divisor, 32-bit quotient, overflow flag.
module ohce_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [31:0]                 mag,
	input  logic [ohce_pkg::PROB_W-1:0] divisor,
	output ohce_pkg::unit_stat_t        stat,
	output logic [31:0]                 quot,
	output logic                        ovf
);
	import ohce_pkg::*;

	div_state_t        state_q, state_d;
	logic [PROB_W-1:0] div_q;
	logic [PROB_W-1:0] rem_q;
	logic [31:0]       dvd_q;
	logic [4:0]        cnt_q;
	logic              ovf_q;

	logic [PROB_W:0]   trial;
	logic [PROB_W:0]   diff;
	logic              ge;
	logic              too_big;

	// quotient needs more than 32 bits when the top of the dividend reaches the divisor
	assign too_big = ({1'b0, mag[31:17]} >= divisor);

	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE: begin
				if (start) state_d = too_big ? DV_DONE : DV_RUN;
			end
			DV_RUN:  if (cnt_q == 5'd31) state_d = DV_DONE;
			DV_DONE: state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					div_q <= divisor;
					ovf_q <= too_big;
					rem_q <= {1'b0, mag[31:17]};
					dvd_q <= {mag[16:0], 15'b0};
					cnt_q <= '0;
				end
			end
			DV_RUN: begin
				rem_q <= ge ? diff[PROB_W-1:0] : trial[PROB_W-1:0];
				dvd_q <= {dvd_q[30:0], ge};
				cnt_q <= cnt_q + 5'd1;
			end
			default: ;
		endcase
	end

	assign stat.busy = (state_q != DV_IDLE);
	assign stat.done = (state_q == DV_DONE);
	assign quot      = dvd_q;
	assign ovf       = ovf_q;

endmodule

// ----- src/one_hot_cross_entropy_unit.sv -----
// Top level of the one-hot cross-entropy unit: sequencer, loss hold and result register.
// Takes one element at a time and drops ready until that element is finished. A forward
// hot element with 0 < p < 1 runs the logarithm unit: k normalize shifts (k = leading
// zeros of p below 1.0, 1 to 15), 16 squarings, one scaling step and a done step, the
// squarings and the scaling on the one multiplier. A backward hot element with p > 0
// runs the 32-step shift-subtract divider, which skips its steps when the quotient
// cannot fit in 32 bits. All other elements need neither unit. A result load waits
// while the result register still holds an untaken result. A loss result appears only
// on a forward row_last element. The result register lets the unit go on with the next
// element while a result waits.
module one_hot_cross_entropy_unit (
	input  logic clk,
	input  logic arst_n,
	ohce_in_if.sink    item,
	ohce_out_if.source result
);
	import ohce_pkg::*;

	top_state_t state_q, state_d;

	logic              accept;
	logic              fwd_log;
	logic              bwd_div;
	logic              out_free;
	logic              load;
	logic [31:0]       mag_in;

	logic              op_q;
	logic              last_q;
	logic              up_neg_q;
	logic signed [GRAD_W-1:0] gin_q;
	logic signed [GRAD_W-1:0] grad_res_q;
	logic              sat_res_q;

	logic [LOSS_W-1:0] held_loss_q;
	logic              held_sat_q;

	logic              out_valid_q;
	logic              out_kind_q;
	logic [LOSS_W-1:0] out_loss_q;
	logic signed [GRAD_W-1:0] out_grad_q;
	logic              out_sat_q;

	unit_stat_t        log_stat;
	unit_stat_t        div_stat;
	logic [LOSS_W-1:0] log_loss;
	logic [31:0]       div_quot;
	logic              div_ovf;

	logic signed [33:0] sum;
	logic               sum_ovf;
	logic signed [GRAD_W-1:0] div_grad;
	logic               div_sat;
	logic signed [GRAD_W-1:0] pass_grad;
	logic               pass_sat;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;

	assign fwd_log = (item.op == OP_FWD) && item.target_hot && (item.prob != '0)
		&& (item.prob < ONE_Q15);
	assign bwd_div = (item.op == OP_BWD) && item.target_hot && (item.prob != '0);

	assign mag_in = item.upstream_grad[GRAD_W-1] ? 32'(-item.upstream_grad)
		: 32'(item.upstream_grad);

	ohce_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && fwd_log),
		.prob   (item.prob),
		.stat   (log_stat),
		.loss   (log_loss)
	);

	ohce_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && bwd_div),
		.mag     (mag_in),
		.divisor (item.prob),
		.stat    (div_stat),
		.quot    (div_quot),
		.ovf     (div_ovf)
	);

	// gradient for backward elements that need no division
	always_comb begin
		pass_grad = item.grad_in;
		pass_sat  = 1'b0;
		if (item.target_hot && (item.prob == '0)) begin
			pass_sat = 1'b1;
			if (item.upstream_grad > 0) begin
				pass_grad = GRAD_MIN;
			end else if (item.upstream_grad < 0) begin
				pass_grad = GRAD_MAX;
			end
		end
	end

	// -up/p added to grad_in, saturated
	assign sum = up_neg_q ? (34'(gin_q) + $signed({2'b0, div_quot}))
		: (34'(gin_q) - $signed({2'b0, div_quot}));
	assign sum_ovf = (sum[33:31] != 3'b000) && (sum[33:31] != 3'b111);

	always_comb begin
		if (div_ovf) begin
			div_grad = up_neg_q ? GRAD_MAX : GRAD_MIN;
			div_sat  = 1'b1;
		end else if (sum_ovf) begin
			div_grad = sum[33] ? GRAD_MIN : GRAD_MAX;
			div_sat  = 1'b1;
		end else begin
			div_grad = sum[GRAD_W-1:0];
			div_sat  = 1'b0;
		end
	end

	assign out_free = !out_valid_q || result.ready;
	assign load     = (state_q == ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (fwd_log) begin
						state_d = ST_LOG;
					end else if (bwd_div) begin
						state_d = ST_DIV;
					end else if ((item.op == OP_BWD) || item.row_last) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_LOG: begin
				if (log_stat.done) state_d = last_q ? ST_EMIT : ST_IDLE;
			end
			ST_DIV:  if (div_stat.done) state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// row hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_loss_q <= '0;
			held_sat_q  <= 1'b0;
		end else if (accept && (item.op == OP_FWD) && item.target_hot && !fwd_log) begin
			// zero probability saturates, one or more gives zero loss
			held_loss_q <= (item.prob == '0) ? LOSS_MAX : '0;
			held_sat_q  <= (item.prob == '0);
		end else if ((state_q == ST_LOG) && log_stat.done) begin
			held_loss_q <= log_loss;
			held_sat_q  <= 1'b0;
		end else if (load && (op_q == OP_FWD)) begin
			held_loss_q <= '0;
			held_sat_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= item.op;
			last_q     <= item.row_last;
			up_neg_q   <= item.upstream_grad[GRAD_W-1];
			gin_q      <= item.grad_in;
			grad_res_q <= pass_grad;
			sat_res_q  <= pass_sat;
		end else if ((state_q == ST_DIV) && div_stat.done) begin
			grad_res_q <= div_grad;
			sat_res_q  <= div_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q <= (op_q == OP_BWD) ? KIND_GRAD : KIND_LOSS;
			out_loss_q <= (op_q == OP_BWD) ? '0 : held_loss_q;
			out_grad_q <= (op_q == OP_BWD) ? grad_res_q : '0;
			out_sat_q  <= (op_q == OP_BWD) ? sat_res_q : held_sat_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.loss        = out_loss_q;
	assign result.grad_out    = out_grad_q;
	assign result.saturated   = out_sat_q;

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!log_stat.busy && !div_stat.busy))
		else $error("arithmetic unit busy while sequencer idle");

	a_log_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		log_stat.done |-> (state_q == ST_LOG))
		else $error("log unit finished outside its sequencer state");

	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside its sequencer state");

	a_hold_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (op_q == OP_FWD)) |=> ((held_loss_q == '0) && !held_sat_q))
		else $error("row hold not cleared after loss transfer");

	a_sat_loss_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == KIND_LOSS) && out_sat_q) |-> (out_loss_q == LOSS_MAX))
		else $error("saturated loss result is not full scale");

endmodule
